// ===== hdl/extent_map_block_translator_assert.svh =====
// assertion macros for the extent map translator
`ifndef EXTENT_MAP_BLOCK_TRANSLATOR_ASSERT_SVH
`define EXTENT_MAP_BLOCK_TRANSLATOR_ASSERT_SVH
`ifndef SYNTH
`define EMBT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define EMBT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define EMBT_ASSERT_IMP(label, clk, rst_n, a, c)
`define EMBT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/embt_pkg.sv =====
// ----------------------------------------------------------------------------
// embt_pkg
// shared types and command codes of the extent map translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package embt_pkg;
    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_SEEK_BLK  = 3'd1;
    localparam logic [2:0] CMD_NEXT_BLK  = 3'd2;
    localparam logic [2:0] CMD_SEEK_EXT  = 3'd3;
    localparam logic [2:0] CMD_NEXT_EXT  = 3'd4;
    localparam logic [2:0] CMD_REMAIN    = 3'd5;
    localparam logic [2:0] CMD_REMAIN_TO = 3'd6;

    // one extent record as it moves along the chain
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic [63:0] end_sum;
        logic [63:0] begin_sum;
    } ext_rec_t;
endpackage

// ===== hdl/embt_cell.sv =====
// ----------------------------------------------------------------------------
// embt_cell
// one extent slot: holds a record and hands it to its neighbor on a shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module embt_cell
    import embt_pkg::*;
(
    input  logic     clk,
    input  logic     shift,
    input  logic     load,
    input  ext_rec_t rec_in,
    input  ext_rec_t load_rec,
    output ext_rec_t rec
);
    ext_rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= load_rec;
        end
        else if (shift)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec = rec_reg;
endmodule

// ===== hdl/extent_map_block_translator.sv =====
// ----------------------------------------------------------------------------
// extent_map_block_translator
// logical to physical block translation over a chain of extent cells
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on the result ports with done high for one cycle, and the receiver cannot
// stall it. Extents live in a ring of MAX_EXTENTS cells that rotates one cell
// a cycle while a request turns it; the extent in cell 0 is the one worked on.
// A request that needs a particular extent (load writes the next free slot,
// next block, seek extent, next extent, remaining) rotates the ring by d cells
// after its check, then applies and raises done; d is the rotation distance
// from the extent at the head to the one needed, 0 to MAX_EXTENTS-1. A seek by
// block turns the ring once, then applies and raises done. A request that
// fails its range check, or an unused command, goes from check to done.
`timescale 1ns / 1ps
module extent_map_block_translator
    import embt_pkg::*;
#(
    parameter int MAX_EXTENTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic        first,
    input  logic [63:0] phys_begin,
    input  logic [63:0] block_length,
    input  logic [63:0] logical_block,
    input  logic [5:0]  extent_index,
    output logic        done,
    output logic        ok,
    output logic [63:0] cur_logical,
    output logic [63:0] cur_physical,
    output logic [5:0]  cur_extent,
    output logic [63:0] remaining,
    output logic [63:0] total_blocks,
    output logic [6:0]  extent_total,
    output logic        at_last_block,
    output logic        at_last_extent
);
`include "extent_map_block_translator_assert.svh"
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int XW = (CW + 1 > 7) ? CW + 1 : 7;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_ROT   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [2:0]     cmd_reg;
    logic           first_reg;
    logic [63:0]    target_reg, pbeg_reg, blen_reg;
    logic [5:0]     idx_reg;
    logic [IW-1:0]  goal_reg;        // extent that must reach the head
    logic [IW-1:0]  head_reg;        // extent index now in cell 0
    logic [CW-1:0]  count_reg;
    logic [63:0]    total_reg, cl_reg, cp_reg;
    logic [IW-1:0]  ce_reg;
    logic           ok_reg;
    logic [63:0]    rem_reg;
    logic [IW-1:0]  scan_cnt_reg;
    logic           found_reg;
    logic [IW-1:0]  fidx_reg;
    logic [63:0]    fphys_reg;
    logic [63:0]    first_start_reg; // physical start of extent zero

    ext_rec_t       rec [MAX_EXTENTS];
    ext_rec_t       new_rec;
    logic           shift, load_head;

    logic           is_load_first;
    logic [CW-1:0]  base_count;
    logic [63:0]    base_total;
    logic           last_blk, last_ext_f;
    logic           guard;
    logic [IW-1:0]  goal_c;
    logic [IW-1:0]  head_inc;
    logic [63:0]    left_ext, to_blk, step_lgc;
    logic           live_head, hit;
    logic [63:0]    hit_phys;

    // cell k holds extent (head+k) mod MAX_EXTENTS, each shift moves one left
    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++)
        begin : g_cell
            logic cell_load;
            assign cell_load = (g == 0) ? load_head : 1'b0;
            embt_cell u_cell (
                .clk(clk), .shift(shift), .load(cell_load),
                .rec_in(rec[(g + 1) % MAX_EXTENTS]), .load_rec(new_rec),
                .rec(rec[g])
            );
        end
    endgenerate

    assign is_load_first = (cmd_reg == CMD_LOAD) && first_reg;
    assign base_count    = is_load_first ? '0 : count_reg;
    assign base_total    = is_load_first ? '0 : total_reg;

    assign new_rec = '{start: pbeg_reg, length: blen_reg,
                       end_sum: total_reg + blen_reg, begin_sum: total_reg};

    assign last_blk   = (total_reg == '0) || (cl_reg >= total_reg - 64'd1);
    assign last_ext_f = (count_reg == '0) ||
                        (XW'(ce_reg) + XW'(1) >= XW'(count_reg));

    assign head_inc = (head_reg == IW'(MAX_EXTENTS - 1)) ? '0 : head_reg + 1'b1;

    assign left_ext = rec[0].length - (cl_reg - rec[0].begin_sum);
    assign to_blk   = target_reg - cl_reg;
    assign step_lgc = cl_reg + 64'd1;

    // seek match at the head; a higher extent replaces an earlier match
    assign live_head = XW'(head_reg) < XW'(count_reg);
    assign hit       = live_head && rec[0].begin_sum <= target_reg
                       && target_reg < rec[0].end_sum
                       && (!found_reg || head_reg > fidx_reg);
    assign hit_phys  = rec[0].start + (target_reg - rec[0].begin_sum);

    assign shift     = (state_reg == ST_ROT && head_reg != goal_reg) ||
                       (state_reg == ST_SCAN);
    assign load_head = (state_reg == ST_APPLY) && (cmd_reg == CMD_LOAD);

    always_comb
    begin
        guard  = 1'b0;
        goal_c = ce_reg;
        unique case (cmd_reg)
            CMD_LOAD:
            begin
                guard  = base_count < CW'(MAX_EXTENTS);
                goal_c = IW'(base_count);
            end
            CMD_SEEK_BLK:
            begin
                guard = target_reg < total_reg;
            end
            CMD_NEXT_BLK:
            begin
                guard = (count_reg != '0) && !last_blk;
            end
            CMD_SEEK_EXT:
            begin
                guard  = XW'(idx_reg) < XW'(count_reg);
                goal_c = IW'(idx_reg);
            end
            CMD_NEXT_EXT:
            begin
                guard  = !last_ext_f;
                goal_c = ce_reg + 1'b1;
            end
            CMD_REMAIN, CMD_REMAIN_TO:
            begin
                guard = (count_reg != '0);
            end
            default:
            begin
                guard = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!guard)
                begin
                    state_next = ST_DONE;
                end
                else if (cmd_reg == CMD_SEEK_BLK)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (head_reg == goal_reg)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == IW'(MAX_EXTENTS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_LOAD;
            first_reg       <= 1'b0;
            target_reg      <= '0;
            pbeg_reg        <= '0;
            blen_reg        <= '0;
            idx_reg         <= '0;
            goal_reg        <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            total_reg       <= '0;
            cl_reg          <= '0;
            cp_reg          <= '0;
            ce_reg          <= '0;
            ok_reg          <= 1'b0;
            rem_reg         <= '0;
            scan_cnt_reg    <= '0;
            found_reg       <= 1'b0;
            fidx_reg        <= '0;
            fphys_reg       <= '0;
            first_start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift)
            begin
                head_reg <= head_inc;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd;
                        first_reg  <= first;
                        target_reg <= logical_block;
                        pbeg_reg   <= phys_begin;
                        blen_reg   <= block_length;
                        idx_reg    <= extent_index;
                        ok_reg     <= 1'b0;
                        rem_reg    <= '0;
                    end
                end
                ST_CHECK:
                begin
                    goal_reg     <= goal_c;
                    scan_cnt_reg <= '0;
                    found_reg    <= 1'b0;
                    // a load that starts a new map clears the totals first
                    if (cmd_reg == CMD_LOAD)
                    begin
                        count_reg <= base_count;
                        total_reg <= base_total;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= head_reg;
                        fphys_reg <= hit_phys;
                    end
                end
                ST_APPLY:
                begin
                    ok_reg <= 1'b1;
                    unique case (cmd_reg)
                        CMD_LOAD:
                        begin
                            count_reg <= count_reg + 1'b1;
                            total_reg <= total_reg + blen_reg;
                            ce_reg    <= '0;
                            cl_reg    <= '0;
                            if (count_reg == '0)
                            begin
                                first_start_reg <= pbeg_reg;
                                cp_reg          <= pbeg_reg;
                            end
                            else
                            begin
                                cp_reg <= first_start_reg;
                            end
                        end
                        CMD_SEEK_BLK:
                        begin
                            // no match only after the sums wrap: keep the physical place and extent
                            cl_reg <= target_reg;
                            if (found_reg)
                            begin
                                cp_reg <= fphys_reg;
                                ce_reg <= fidx_reg;
                            end
                        end
                        CMD_NEXT_BLK:
                        begin
                            cl_reg <= step_lgc;
                            if ((step_lgc - rec[0].begin_sum) < rec[0].length
                                || last_ext_f)
                            begin
                                cp_reg <= cp_reg + 64'd1;
                            end
                            else
                            begin
                                ce_reg <= ce_reg + 1'b1;
                                cp_reg <= rec[1 % MAX_EXTENTS].start;
                            end
                        end
                        CMD_SEEK_EXT, CMD_NEXT_EXT:
                        begin
                            ce_reg <= head_reg;
                            cl_reg <= rec[0].begin_sum;
                            cp_reg <= rec[0].start;
                        end
                        CMD_REMAIN:
                        begin
                            rem_reg <= left_ext;
                        end
                        CMD_REMAIN_TO:
                        begin
                            if (target_reg > cl_reg)
                            begin
                                rem_reg <= (left_ext < to_blk) ? left_ext : to_blk;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign ok             = ok_reg;
    assign cur_logical    = cl_reg;
    assign cur_physical   = cp_reg;
    assign cur_extent     = 6'(ce_reg);
    assign remaining      = rem_reg;
    assign total_blocks   = total_reg;
    assign extent_total   = 7'(count_reg);
    assign at_last_block  = last_blk;
    assign at_last_extent = last_ext_f;

    `EMBT_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `EMBT_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_EXTENTS))
    `EMBT_ASSERT_NXT(a_take, clk, rst_n, start && !busy, busy)
    `EMBT_ASSERT_IMP(a_done_ok_rem, clk, rst_n, done && !ok, rem_reg == '0)
    `EMBT_ASSERT_IMP(a_head_range, clk, rst_n, 1'b1, XW'(head_reg) < XW'(MAX_EXTENTS))
endmodule

// ===== sim/tb_extent_map_block_translator.sv =====
// ----------------------------------------------------------------------------
// tb_extent_map_block_translator
// self-checking bench: directed table of requests then random extent maps
// with navigation, every result checked against a behavioral translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_extent_map_block_translator;
    import embt_pkg::*;

    localparam int          NEXT   = 64;
    localparam logic [2:0]  CMD_UNUSED = 3'd7;
    localparam logic [63:0] ALL1   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          WDOG   = 4000;

    typedef struct {
        logic        ok;
        logic [63:0] lgc;
        logic [63:0] phy;
        logic [5:0]  ext;
        logic [63:0] rem;
        logic [63:0] total;
        logic [6:0]  count;
        logic        last_blk;
        logic        last_ext;
    } xlat_res_t;

    typedef struct {
        logic [2:0]  cmd;
        logic        first;
        logic [63:0] pb;
        logic [63:0] len;
        logic [63:0] lb;
        logic [5:0]  idx;
        int          ok_typed; // -1: predictor only
    } req_row_t;

    logic clk, rst_n, start, busy, done;
    logic [2:0]  cmd;
    logic        first;
    logic [63:0] phys_begin, block_length, logical_block;
    logic [5:0]  extent_index;
    logic        ok, at_last_block, at_last_extent;
    logic [63:0] cur_logical, cur_physical, remaining, total_blocks;
    logic [5:0]  cur_extent;
    logic [6:0]  extent_total;

    extent_map_block_translator dut (.*);

    // shadow extent map
    logic [63:0] m_start [NEXT];
    logic [63:0] m_len   [NEXT];
    logic [63:0] m_end   [NEXT];
    int          m_count;
    logic [63:0] m_total, c_lgc, c_phy;
    int          c_ext;

    xlat_res_t   pending_q[$];
    int          typed_ok;
    int          req_count, err_count, idle_cycles;

    function automatic logic [63:0] ext_base(int e);
        return (e == 0) ? 64'd0 : m_end[e-1];
    endfunction

    function automatic logic [63:0] left_in_ext();
        return m_len[c_ext] - (c_lgc - ext_base(c_ext));
    endfunction

    function automatic xlat_res_t translate(logic [2:0] op, logic fst, logic [63:0] pb,
                                            logic [63:0] len, logic [63:0] tgt,
                                            logic [5:0] idx);
        xlat_res_t   r;
        logic [63:0] b, to_ext, to_blk;
        r.ok  = 1'b0;
        r.rem = 64'd0;
        case (op)
            CMD_LOAD: begin
                if (fst) begin
                    m_count = 0;
                    m_total = 64'd0;
                end
                if (m_count < NEXT) begin
                    m_total = m_total + len;
                    m_start[m_count] = pb;
                    m_len[m_count]   = len;
                    m_end[m_count]   = m_total;
                    m_count++;
                    c_ext = 0;
                    c_lgc = 64'd0;
                    c_phy = m_start[0];
                    r.ok  = 1'b1;
                end
            end
            CMD_SEEK_BLK: begin
                if (tgt < m_total) begin
                    c_lgc = tgt;
                    for (int i = 0; i < m_count; i++) begin
                        b = ext_base(i);
                        if (b <= tgt && tgt < m_end[i]) begin
                            c_phy = m_start[i] + (tgt - b);
                            c_ext = i;
                        end
                    end
                    r.ok = 1'b1;
                end
            end
            CMD_NEXT_BLK: begin
                if (m_count != 0 && m_total != 0 && c_lgc < m_total - 1) begin
                    c_lgc++;
                    if (c_lgc - ext_base(c_ext) < m_len[c_ext] || c_ext + 1 >= m_count)
                        c_phy++;
                    else begin
                        c_ext++;
                        c_phy = m_start[c_ext];
                    end
                    r.ok = 1'b1;
                end
            end
            CMD_SEEK_EXT, CMD_NEXT_EXT: begin
                b = (op == CMD_SEEK_EXT) ? 64'(idx) : 64'(c_ext + 1);
                if (m_count != 0 && b < m_count) begin
                    c_ext = int'(b);
                    c_lgc = ext_base(c_ext);
                    c_phy = m_start[c_ext];
                    r.ok  = 1'b1;
                end
            end
            CMD_REMAIN: begin
                if (m_count != 0) begin
                    r.rem = left_in_ext();
                    r.ok  = 1'b1;
                end
            end
            CMD_REMAIN_TO: begin
                if (m_count != 0) begin
                    if (tgt > c_lgc) begin
                        to_ext = left_in_ext();
                        to_blk = tgt - c_lgc;
                        r.rem  = (to_ext < to_blk) ? to_ext : to_blk;
                    end
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.lgc      = c_lgc;
        r.phy      = c_phy;
        r.ext      = c_ext[5:0];
        r.total    = m_total;
        r.count    = m_count[6:0];
        r.last_blk = (m_total == 0) || (c_lgc >= m_total - 1);
        r.last_ext = (m_count == 0) || (c_ext + 1 >= m_count);
        return r;
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // acceptance, result checking and watchdog
    always @(posedge clk) begin
        xlat_res_t e;
        if (rst_n) begin
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done) begin
                if (pending_q.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    e = pending_q.pop_front();
                    if (ok !== e.ok) begin
                        $error("ok exp %0d got %0d", e.ok, ok); err_count++;
                    end
                    if (cur_logical !== e.lgc) begin
                        $error("cur_logical exp %0h got %0h", e.lgc, cur_logical);
                        err_count++;
                    end
                    if (cur_physical !== e.phy) begin
                        $error("cur_physical exp %0h got %0h", e.phy, cur_physical);
                        err_count++;
                    end
                    if (cur_extent !== e.ext) begin
                        $error("cur_extent exp %0d got %0d", e.ext, cur_extent);
                        err_count++;
                    end
                    if (remaining !== e.rem) begin
                        $error("remaining exp %0h got %0h", e.rem, remaining);
                        err_count++;
                    end
                    if (total_blocks !== e.total) begin
                        $error("total_blocks exp %0h got %0h", e.total, total_blocks);
                        err_count++;
                    end
                    if (extent_total !== e.count) begin
                        $error("extent_total exp %0d got %0d", e.count, extent_total);
                        err_count++;
                    end
                    if (at_last_block !== e.last_blk) begin
                        $error("at_last_block exp %0d got %0d", e.last_blk, at_last_block);
                        err_count++;
                    end
                    if (at_last_extent !== e.last_ext) begin
                        $error("at_last_extent exp %0d got %0d", e.last_ext, at_last_extent);
                        err_count++;
                    end
                end
            end
            if (start && !busy) begin
                e = translate(cmd, first, phys_begin, block_length, logical_block,
                              extent_index);
                if (typed_ok >= 0 && e.ok !== typed_ok[0]) begin
                    $error("ok exp %0d got %0d (table)", typed_ok, e.ok);
                    err_count++;
                end
                pending_q.push_back(e);
                req_count <= req_count + 1;
            end
            if (idle_cycles >= WDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic issue(logic [2:0] op, logic fst, logic [63:0] pb, logic [63:0] len,
                         logic [63:0] tgt, logic [5:0] idx, int tok);
        int gap, seen;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd           <= op;
        first         <= fst;
        phys_begin    <= pb;
        block_length  <= len;
        logical_block <= tgt;
        extent_index  <= idx;
        typed_ok       = tok;
        start         <= 1'b1;
        seen = req_count;
        do @(negedge clk); while (req_count == seen);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return rand64();
            1:       return 64'd0;
            default: return 64'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [63:0] pick_target();
        case ($urandom_range(0, 7))
            0:       return rand64();
            1:       return m_total - 64'($urandom_range(0, 2));
            default: return 64'($urandom_range(0, 40));
        endcase
    endfunction

    req_row_t dir_rows[] = '{
        '{CMD_NEXT_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_NEXT_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_REMAIN,    1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_SEEK_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_SEEK_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_REMAIN_TO, 1'b0, 64'd0,  64'd0, ALL1,  6'd0,  0},
        '{CMD_UNUSED,    1'b1, ALL1,   ALL1,  ALL1,  6'd63, 0},
        '{CMD_LOAD,      1'b1, ALL1,   64'd5, 64'd0, 6'd0,  1},
        '{CMD_LOAD,      1'b0, 64'd100, 64'd0, 64'd0, 6'd0, 1},
        '{CMD_LOAD,      1'b0, 64'd0,  64'd3, 64'd0, 6'd0,  1},
        '{CMD_SEEK_BLK,  1'b0, 64'd0,  64'd0, 64'd4, 6'd0, -1},
        '{CMD_NEXT_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1},
        '{CMD_NEXT_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1},
        '{CMD_REMAIN_TO, 1'b0, 64'd0,  64'd0, ALL1,  6'd0, -1},
        '{CMD_REMAIN,    1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1},
        '{CMD_SEEK_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd1, -1},
        '{CMD_SEEK_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd63, 0},
        '{CMD_NEXT_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1},
        '{CMD_NEXT_EXT,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0,  0},
        '{CMD_SEEK_BLK,  1'b0, 64'd0,  64'd0, ALL1,  6'd0,  0},
        '{CMD_LOAD,      1'b1, 64'd7,  ALL1,  64'd0, 6'd0,  1},
        // running end wraps past zero
        '{CMD_LOAD,      1'b0, ALL1,   64'd2, 64'd0, 6'd0,  1},
        '{CMD_SEEK_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1},
        '{CMD_NEXT_BLK,  1'b0, 64'd0,  64'd0, 64'd0, 6'd0, -1}
    };

    initial begin
        int n_ext, n_nav, op;
        logic [2:0] nav_op;
        rst_n = 1'b0; start = 1'b0; cmd = CMD_LOAD; first = 1'b0;
        phys_begin = '0; block_length = '0; logical_block = '0; extent_index = '0;
        typed_ok = -1; req_count = 0; err_count = 0; idle_cycles = 0;
        m_count = 0; m_total = '0; c_lgc = '0; c_phy = '0; c_ext = 0;
        for (int i = 0; i < NEXT; i++) begin
            m_start[i] = '0; m_len[i] = '0; m_end[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            issue(dir_rows[i].cmd, dir_rows[i].first, dir_rows[i].pb, dir_rows[i].len,
                  dir_rows[i].lb, dir_rows[i].idx, dir_rows[i].ok_typed);

        // random maps, each followed by a walk over it
        while (req_count < 680) begin
            n_ext = ($urandom_range(0, 14) == 0) ? $urandom_range(64, 67)
                                                  : $urandom_range(1, 8);
            for (int i = 0; i < n_ext; i++)
                issue(CMD_LOAD, i == 0 || $urandom_range(0, 30) == 0, rand64(),
                      pick_len(), rand64(), 6'($urandom_range(0, 63)), -1);
            n_nav = $urandom_range(4, 16);
            for (int i = 0; i < n_nav; i++) begin
                op = $urandom_range(0, 40);
                if (op == 0)       nav_op = CMD_UNUSED;
                else if (op == 1)  nav_op = CMD_LOAD;
                else if (op < 12)  nav_op = CMD_NEXT_BLK;
                else               nav_op = 3'($urandom_range(1, 6));
                issue(nav_op, 1'($urandom_range(0, 1)), rand64(), pick_len(),
                      pick_target(),
                      6'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, m_count + 1)),
                      -1);
            end
        end

        start <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
